// ----- src/tclp_pkg.sv -----
// ----------------------------------------------------------------------------
// tclp_pkg
// Shared types and constants of the text command line parser: character
// classes, queue entries, result records and the keyword tables.
// ----------------------------------------------------------------------------
`default_nettype none

package tclp_pkg;

  localparam int KW_COUNT     = 16;
  localparam int KW_WRITE_BIT = 11;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int TDATA_W      = 80;

  typedef enum logic [1:0] {
    CH_TOKEN = 2'd0,
    CH_SEP   = 2'd1,
    CH_TERM  = 2'd2
  } ch_kind_t;

  typedef enum logic [3:0] {
    CMD_NONE    = 4'd0,
    CMD_PING    = 4'd1,
    CMD_HELP    = 4'd2,
    CMD_INFO    = 4'd3,
    CMD_STATUS  = 4'd4,
    CMD_FLASH   = 4'd5,
    CMD_READ    = 4'd6,
    CMD_ERASE   = 4'd7,
    CMD_WRITE   = 4'd8,
    CMD_CRC     = 4'd9,
    CMD_BOOT    = 4'd10,
    CMD_RESET   = 4'd11,
    CMD_UNKNOWN = 4'd12
  } cmd_type_t;

  typedef enum logic {
    KIND_TEXT    = 1'b0,
    KIND_COMMAND = 1'b1
  } item_kind_t;

  typedef struct packed {
    ch_kind_t    kind;
    logic [7:0]  ch;
    logic        is_digit;
    logic [3:0]  digit;
  } q_item_t;

  typedef struct packed {
    item_kind_t  item_kind;
    logic [7:0]  text_byte;
    cmd_type_t   command_type;
    logic [31:0] offset_value;
    logic [31:0] size_value;
    logic        offset_valid;
    logic        size_valid;
  } res_t;

  localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
    '{"P", "I", "N", "G", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"H", "E", "L", "P", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"?", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"I", "N", "F", "O", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"S", "T", "A", "T", "U", "S", 8'h00, 8'h00},
    '{"D", "I", "A", "G", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"F", "L", "A", "S", "H", 8'h00, 8'h00, 8'h00},
    '{"M", "A", "P", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"R", "E", "A", "D", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"D", "U", "M", "P", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"E", "R", "A", "S", "E", 8'h00, 8'h00, 8'h00},
    '{"W", "R", "I", "T", "E", 8'h00, 8'h00, 8'h00},
    '{"C", "R", "C", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"B", "O", "O", "T", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"S", "T", "A", "R", "T", 8'h00, 8'h00, 8'h00},
    '{"R", "E", "S", "E", "T", 8'h00, 8'h00, 8'h00}
  };

  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd4, 3'd4, 3'd1, 3'd4, 3'd6, 3'd4, 3'd5, 3'd3,
    3'd4, 3'd4, 3'd5, 3'd5, 3'd3, 3'd4, 3'd5, 3'd5
  };

  localparam cmd_type_t KW_TYPE [KW_COUNT] = '{
    CMD_PING, CMD_HELP, CMD_HELP, CMD_INFO, CMD_STATUS, CMD_STATUS, CMD_FLASH, CMD_FLASH,
    CMD_READ, CMD_READ, CMD_ERASE, CMD_WRITE, CMD_CRC, CMD_BOOT, CMD_BOOT, CMD_RESET
  };

endpackage

`default_nettype wire

// ----- src/tclp_front.sv -----
// ----------------------------------------------------------------------------
// tclp_front
// Input side: accepts characters and classifies each one as terminator,
// separator or token character, upper-casing letters and decoding digits.
// ----------------------------------------------------------------------------
`default_nettype none

module tclp_front
  import tclp_pkg::*;
(
  input  wire logic    in_tvalid,
  output logic         in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] char_in
  output logic         q_wr_valid,
  output q_item_t      q_wr_item,
  input  wire logic    q_wr_ready
);

  logic [7:0] c;

  assign c          = in_tdata;
  assign in_tready  = q_wr_ready;
  assign q_wr_valid = in_tvalid;

  always_comb begin
    q_wr_item          = '0;
    q_wr_item.kind     = CH_TOKEN;
    q_wr_item.ch       = c;
    q_wr_item.is_digit = c inside {[8'h30:8'h39]};
    q_wr_item.digit    = c[3:0];
    if (c == 8'h00) begin
      q_wr_item.kind = CH_TERM;
    end else if (c inside {8'h20, 8'h09, 8'h0D, 8'h0A}) begin
      q_wr_item.kind = CH_SEP;
    end else if (c inside {[8'h61:8'h7A]}) begin
      q_wr_item.ch = c - 8'h20;
    end
  end

endmodule

`default_nettype wire

// ----- src/tclp_queue.sv -----
// ----------------------------------------------------------------------------
// tclp_queue
// Short first-in first-out queue of classified characters between the input
// side and the parser, so that each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module tclp_queue
  import tclp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    wr_valid,
  input  q_item_t      wr_item,
  output logic         wr_ready,
  output logic         rd_valid,
  output q_item_t      rd_item,
  input  wire logic    rd_ready
);

  q_item_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              do_wr;
  logic              do_rd;

  assign wr_ready = (count_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_item  = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/tclp_back.sv -----
// ----------------------------------------------------------------------------
// tclp_back
// Parser: builds the three tokens one character at a time, tracks keyword
// matches and decimal arguments, emits payload bytes and the command result.
// ----------------------------------------------------------------------------
`default_nettype none

module tclp_back
  import tclp_pkg::*;
#(
  parameter int KEYWORD_TOKEN_CHARS = 31,
  parameter int ARG_TOKEN_CHARS     = 31,
  parameter int TEXT_TOKEN_CHARS    = 259,
  parameter int TEXT_BYTES          = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  q_item_t   q_item,
  output logic      q_ready,
  output logic      res_valid,
  output res_t      res,
  input  wire logic res_ready
);

  localparam int MAX_LIM_A = (KEYWORD_TOKEN_CHARS > ARG_TOKEN_CHARS) ?
                             KEYWORD_TOKEN_CHARS : ARG_TOKEN_CHARS;
  localparam int MAX_LIM   = (MAX_LIM_A > TEXT_TOKEN_CHARS) ? MAX_LIM_A : TEXT_TOKEN_CHARS;
  localparam int CNT_W     = $clog2(MAX_LIM + 1);
  localparam int SENT_W    = $clog2(TEXT_BYTES + 1);

  logic [1:0]          tok_num_r,   tok_num_nxt;
  logic                in_tok_r,    in_tok_nxt;
  logic [CNT_W-1:0]    cnt_r,       cnt_nxt;
  logic [KW_COUNT-1:0] mask_r,      mask_nxt;
  logic                first_r,     first_nxt;
  logic [31:0]         arg1_val_r,  arg1_val_nxt;
  logic [1:0]          arg1_flg_r,  arg1_flg_nxt;
  logic [31:0]         arg2_val_r,  arg2_val_nxt;
  logic [1:0]          arg2_flg_r,  arg2_flg_nxt;
  logic [SENT_W-1:0]   sent_r,      sent_nxt;
  logic                out_valid_r, out_valid_nxt;
  res_t                out_r,       out_nxt;

  logic                pop;
  logic                do_close;
  logic [CNT_W-1:0]    limit;
  cmd_type_t           kt;
  logic                a1;
  logic                a2;

  assign pop       = q_valid && (!out_valid_r || res_ready);
  assign q_ready   = pop;
  assign res_valid = out_valid_r;
  assign res       = out_r;

  always_comb begin
    case (tok_num_r)
      2'd0:    limit = CNT_W'(KEYWORD_TOKEN_CHARS);
      2'd1:    limit = CNT_W'(ARG_TOKEN_CHARS);
      default: limit = CNT_W'(TEXT_TOKEN_CHARS);
    endcase
  end

  always_comb begin
    tok_num_nxt   = tok_num_r;
    in_tok_nxt    = in_tok_r;
    cnt_nxt       = cnt_r;
    mask_nxt      = mask_r;
    first_nxt     = first_r;
    arg1_val_nxt  = arg1_val_r;
    arg1_flg_nxt  = arg1_flg_r;
    arg2_val_nxt  = arg2_val_r;
    arg2_flg_nxt  = arg2_flg_r;
    sent_nxt      = sent_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !res_ready;
    kt            = CMD_NONE;
    a1            = 1'b0;
    a2            = 1'b0;
    do_close      = 1'b0;

    if (pop) begin
      case (q_item.kind)
        CH_TERM, CH_SEP: do_close = in_tok_r;
        CH_TOKEN:        do_close = in_tok_r && (tok_num_r != 2'd3) && (cnt_r >= limit);
        default:         do_close = 1'b0;
      endcase

      if (do_close) begin
        if (tok_num_nxt == 2'd0) begin
          for (int k = 0; k < KW_COUNT; k++) begin
            if (CNT_W'(KW_LEN[k]) != cnt_nxt) begin
              mask_nxt[k] = 1'b0;
            end
          end
          first_nxt = 1'b1;
        end
        if (tok_num_nxt != 2'd3) begin
          tok_num_nxt = tok_num_nxt + 2'd1;
        end
        in_tok_nxt = 1'b0;
        cnt_nxt    = '0;
      end

      case (q_item.kind)
        CH_TERM: begin
          out_nxt           = '0;
          out_nxt.item_kind = KIND_COMMAND;
          a1                = (arg1_flg_r == 2'b01);
          a2                = (arg2_flg_r == 2'b01);
          if (first_nxt) begin
            for (int k = 0; k < KW_COUNT; k++) begin
              if (mask_nxt[k]) begin
                kt = KW_TYPE[k];
              end
            end
            case (kt)
              CMD_NONE: begin
                out_nxt.command_type = CMD_UNKNOWN;
              end
              CMD_READ: begin
                if (a1) begin
                  out_nxt.offset_value = arg1_val_r;
                end
                if (a1 && a2) begin
                  out_nxt.command_type = CMD_READ;
                  out_nxt.size_value   = arg2_val_r;
                  out_nxt.offset_valid = 1'b1;
                  out_nxt.size_valid   = 1'b1;
                end else begin
                  out_nxt.command_type = CMD_UNKNOWN;
                end
              end
              CMD_ERASE, CMD_CRC: begin
                if (a1) begin
                  out_nxt.command_type = kt;
                  out_nxt.size_value   = arg1_val_r;
                  out_nxt.size_valid   = 1'b1;
                end else begin
                  out_nxt.command_type = CMD_UNKNOWN;
                end
              end
              CMD_WRITE: begin
                if (a1) begin
                  out_nxt.offset_value = arg1_val_r;
                end
                if (a1 && arg2_flg_r[0]) begin
                  out_nxt.command_type = CMD_WRITE;
                  out_nxt.offset_valid = 1'b1;
                end else begin
                  out_nxt.command_type = CMD_UNKNOWN;
                end
              end
              default: begin
                out_nxt.command_type = kt;
              end
            endcase
          end
          out_valid_nxt = 1'b1;
          tok_num_nxt   = 2'd0;
          in_tok_nxt    = 1'b0;
          cnt_nxt       = '0;
          mask_nxt      = '1;
          first_nxt     = 1'b0;
          arg1_val_nxt  = '0;
          arg1_flg_nxt  = '0;
          arg2_val_nxt  = '0;
          arg2_flg_nxt  = '0;
          sent_nxt      = '0;
        end
        CH_TOKEN: begin
          if (tok_num_nxt != 2'd3) begin
            in_tok_nxt = 1'b1;
            case (tok_num_nxt)
              2'd0: begin
                for (int k = 0; k < KW_COUNT; k++) begin
                  if ((cnt_nxt >= CNT_W'(KW_LEN[k])) || (KW_TEXT[k][cnt_nxt[2:0]] != q_item.ch)) begin
                    mask_nxt[k] = 1'b0;
                  end
                end
              end
              2'd1: begin
                arg1_flg_nxt[0] = 1'b1;
                if (q_item.is_digit) begin
                  arg1_val_nxt = {arg1_val_r[28:0], 3'b000} + {arg1_val_r[30:0], 1'b0}
                                 + {28'd0, q_item.digit};
                end else begin
                  arg1_flg_nxt[1] = 1'b1;
                end
              end
              default: begin
                arg2_flg_nxt[0] = 1'b1;
                if (q_item.is_digit) begin
                  arg2_val_nxt = {arg2_val_r[28:0], 3'b000} + {arg2_val_r[30:0], 1'b0}
                                 + {28'd0, q_item.digit};
                end else begin
                  arg2_flg_nxt[1] = 1'b1;
                end
                if (mask_nxt[KW_WRITE_BIT] && (arg1_flg_r == 2'b01) &&
                    (sent_r < SENT_W'(TEXT_BYTES))) begin
                  sent_nxt          = sent_r + 1'b1;
                  out_nxt           = '0;
                  out_nxt.item_kind = KIND_TEXT;
                  out_nxt.text_byte = q_item.ch;
                  out_valid_nxt     = 1'b1;
                end
              end
            endcase
            cnt_nxt = cnt_nxt + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (!rst_n) begin
      tok_num_r   <= 2'd0;
      in_tok_r    <= 1'b0;
      cnt_r       <= '0;
      mask_r      <= '1;
      first_r     <= 1'b0;
      arg1_val_r  <= '0;
      arg1_flg_r  <= '0;
      arg2_val_r  <= '0;
      arg2_flg_r  <= '0;
      sent_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tok_num_r   <= tok_num_nxt;
      in_tok_r    <= in_tok_nxt;
      cnt_r       <= cnt_nxt;
      mask_r      <= mask_nxt;
      first_r     <= first_nxt;
      arg1_val_r  <= arg1_val_nxt;
      arg1_flg_r  <= arg1_flg_nxt;
      arg2_val_r  <= arg2_val_nxt;
      arg2_flg_r  <= arg2_flg_nxt;
      sent_r      <= sent_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/text_command_line_parser_core.sv -----
// ----------------------------------------------------------------------------
// text_command_line_parser_core
// Parses a bootloader command line delivered one character per transfer.
// ----------------------------------------------------------------------------
// One character is taken per clock cycle, sustained, while the result side
// keeps up; a zero character ends the line and yields one command result,
// and the first TEXT_BYTES payload bytes of a WRITE appear as text results as
// they arrive. A character's result passes through the classifier queue and
// then through the parser's output register. The parser's per-character
// update compares a keyword character against all keywords, or adds an
// argument character into its decimal argument. A four-entry queue absorbs
// short output stalls.
`default_nettype none

module text_command_line_parser_core
  import tclp_pkg::*;
#(
  parameter int KEYWORD_TOKEN_CHARS = 31,
  parameter int ARG_TOKEN_CHARS     = 31,
  parameter int TEXT_TOKEN_CHARS    = 259,
  parameter int TEXT_BYTES          = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [7:0]         in_tdata,   // [7:0] char_in
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  // [7:0] text_byte, [11:8] command_type, [43:12] offset_value,
  // [75:44] size_value, [76] offset_valid, [77] size_valid, [79:78] zero
  output logic [TDATA_W-1:0]      out_tdata,
  output logic                    out_tuser   // [0] item_kind
);

  logic    q_wr_valid;
  q_item_t q_wr_item;
  logic    q_wr_ready;
  logic    q_rd_valid;
  q_item_t q_rd_item;
  logic    q_rd_ready;
  res_t    res;

  tclp_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .q_wr_valid (q_wr_valid),
    .q_wr_item  (q_wr_item),
    .q_wr_ready (q_wr_ready)
  );

  tclp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (q_wr_valid),
    .wr_item  (q_wr_item),
    .wr_ready (q_wr_ready),
    .rd_valid (q_rd_valid),
    .rd_item  (q_rd_item),
    .rd_ready (q_rd_ready)
  );

  tclp_back #(
    .KEYWORD_TOKEN_CHARS (KEYWORD_TOKEN_CHARS),
    .ARG_TOKEN_CHARS     (ARG_TOKEN_CHARS),
    .TEXT_TOKEN_CHARS    (TEXT_TOKEN_CHARS),
    .TEXT_BYTES          (TEXT_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_rd_valid),
    .q_item    (q_rd_item),
    .q_ready   (q_rd_ready),
    .res_valid (out_tvalid),
    .res       (res),
    .res_ready (out_tready)
  );

  assign out_tuser = res.item_kind;
  assign out_tdata = {2'b00, res.size_valid, res.offset_valid, res.size_value,
                      res.offset_value, res.command_type, res.text_byte};

endmodule

`default_nettype wire

// ----- src/tclp_checker.sv -----
// ----------------------------------------------------------------------------
// tclp_checker
// Port-level checks of the command line parser's result stream, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tclp_checker
  import tclp_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_tvalid,
  input wire logic               out_tready,
  input wire logic [TDATA_W-1:0] out_tdata,
  input wire logic               out_tuser
);

  // A result that has been offered stays unchanged until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // A text result carries nothing but its byte.
  a_text_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[TDATA_W-1:8] == '0)
    else $error("text result carries command fields");

  // An offset is only reported as valid for READ or WRITE.
  a_offset_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && out_tdata[76] |->
      out_tdata[11:8] == CMD_READ || out_tdata[11:8] == CMD_WRITE)
    else $error("offset valid on a command without an offset");

  // A size is only reported as valid for READ, ERASE or CRC, and a command
  // result never carries a text byte.
  a_size_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[7:0] == 8'h00 && (!out_tdata[77] ||
      out_tdata[11:8] == CMD_READ || out_tdata[11:8] == CMD_ERASE ||
      out_tdata[11:8] == CMD_CRC))
    else $error("size valid on a command without a size");

endmodule

bind text_command_line_parser_core tclp_checker u_tclp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the command line parser core. Lines of characters
// are streamed in with random gaps and the result side stalls at random. An
// in-bench parser predicts every text and command result, and each received
// transfer is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tclp_pkg::*;

  localparam int unsigned KEYWORD_CHARS = 31;
  localparam int unsigned ARG_CHARS     = 31;
  localparam int unsigned TEXT_CHARS    = 259;
  localparam int unsigned PAYLOAD_BYTES = 64;
  localparam int          WRITE_SLOT    = 11;
  localparam int unsigned PCT_IDLE      = 9;
  localparam int unsigned RANDOM_CHARS  = 980;
  localparam int unsigned STEADY_CHARS  = 250;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam logic [7:0]  CH_END        = 8'h00;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [7:0]         in_tdata = 8'h00;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic               out_tuser;

  logic               steady = 1'b0;
  int unsigned        chars_sent = 0;
  int unsigned        fails = 0;
  int unsigned        idle_cycles = 0;

  string      kw_word [16] = '{"PING", "HELP", "?", "INFO", "STATUS", "DIAG", "FLASH", "MAP",
                               "READ", "DUMP", "ERASE", "WRITE", "CRC", "BOOT", "START",
                               "RESET"};
  cmd_type_t  kw_cmd [16] = '{CMD_PING, CMD_HELP, CMD_HELP, CMD_INFO, CMD_STATUS, CMD_STATUS,
                              CMD_FLASH, CMD_FLASH, CMD_READ, CMD_READ, CMD_ERASE, CMD_WRITE,
                              CMD_CRC, CMD_BOOT, CMD_BOOT, CMD_RESET};
  logic [7:0] blanks [4] = '{8'h20, 8'h09, 8'h0D, 8'h0A};

  // Shadow parser state.
  logic [1:0]  tok_idx;
  logic        tok_open;
  int unsigned tok_len;
  logic [15:0] kw_alive;
  logic        first_seen;
  logic [31:0] arg_val [2];
  logic [1:0]  arg_flags [2];
  int unsigned text_sent;
  res_t        results_due [$];
  res_t        due_head;

  text_command_line_parser_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  function automatic void clear_line();
    tok_idx = 2'd0;
    tok_open = 1'b0;
    tok_len = 0;
    kw_alive = '1;
    first_seen = 1'b0;
    arg_val = '{32'd0, 32'd0};
    arg_flags = '{2'b00, 2'b00};
    text_sent = 0;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
  endfunction

  function automatic int unsigned token_cap(logic [1:0] idx);
    return (idx == 2'd0) ? KEYWORD_CHARS : (idx == 2'd1) ? ARG_CHARS : TEXT_CHARS;
  endfunction

  function automatic void end_token();
    if (tok_idx == 2'd0) begin
      for (int k = 0; k < 16; k++)
        if (kw_word[k].len() != tok_len) kw_alive[k] = 1'b0;
      first_seen = 1'b1;
    end
    if (tok_idx != 2'd3) tok_idx = tok_idx + 2'd1;
    tok_open = 1'b0;
    tok_len = 0;
  endfunction

  function automatic res_t line_result();
    res_t      r;
    cmd_type_t kt;
    logic      a1;
    logic      a2;
    r = '0;
    r.item_kind = KIND_COMMAND;
    r.command_type = CMD_NONE;
    kt = CMD_NONE;
    if (tok_open) end_token();
    if (first_seen) begin
      a1 = (arg_flags[0] == 2'b01);
      a2 = (arg_flags[1] == 2'b01);
      for (int k = 0; k < 16; k++)
        if (kw_alive[k]) kt = kw_cmd[k];
      case (kt)
        CMD_NONE: r.command_type = CMD_UNKNOWN;
        CMD_READ: begin
          if (a1) r.offset_value = arg_val[0];
          if (a1 && a2) begin
            r.command_type = CMD_READ;
            r.size_value = arg_val[1];
            r.offset_valid = 1'b1;
            r.size_valid = 1'b1;
          end else begin
            r.command_type = CMD_UNKNOWN;
          end
        end
        CMD_ERASE, CMD_CRC: begin
          if (a1) begin
            r.command_type = kt;
            r.size_value = arg_val[0];
            r.size_valid = 1'b1;
          end else begin
            r.command_type = CMD_UNKNOWN;
          end
        end
        CMD_WRITE: begin
          if (a1) r.offset_value = arg_val[0];
          if (a1 && arg_flags[1][0]) begin
            r.command_type = CMD_WRITE;
            r.offset_valid = 1'b1;
          end else begin
            r.command_type = CMD_UNKNOWN;
          end
        end
        default: r.command_type = kt;
      endcase
    end
    return r;
  endfunction

  function automatic void parse_char(logic [7:0] ch);
    logic [7:0] c;
    res_t       r;
    int         i;
    c = ch;
    if (c == CH_END) begin
      results_due.push_back(line_result());
      clear_line();
      return;
    end
    if (is_blank(c)) begin
      if (tok_open) end_token();
      return;
    end
    if (tok_idx == 2'd3) return;
    if (tok_open && tok_len >= token_cap(tok_idx)) begin
      end_token();
      if (tok_idx == 2'd3) return;
    end
    tok_open = 1'b1;
    if (c >= 8'h61 && c <= 8'h7A) c = c - 8'h20;
    if (tok_idx == 2'd0) begin
      for (int k = 0; k < 16; k++)
        if (tok_len >= kw_word[k].len() || kw_word[k][tok_len] != c) kw_alive[k] = 1'b0;
    end else begin
      i = tok_idx - 1;
      arg_flags[i][0] = 1'b1;
      if (c >= 8'h30 && c <= 8'h39) arg_val[i] = arg_val[i] * 32'd10 + (c - 8'h30);
      else arg_flags[i][1] = 1'b1;
      if (tok_idx == 2'd2 && kw_alive[WRITE_SLOT] && arg_flags[0] == 2'b01 &&
          text_sent < PAYLOAD_BYTES) begin
        text_sent++;
        r = '0;
        r.item_kind = KIND_TEXT;
        r.command_type = CMD_NONE;
        r.text_byte = c;
        results_due.push_back(r);
      end
    end
    tok_len++;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s expected %0h got %0h", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (results_due.size() == 0) begin
        $error("result transfer with no pending prediction");
        fails++;
      end else begin
        due_head = results_due.pop_front();
        check_field("item_kind", 32'(due_head.item_kind), 32'(out_tuser));
        check_field("text_byte", 32'(due_head.text_byte), 32'(out_tdata[7:0]));
        check_field("command_type", 32'(due_head.command_type), 32'(out_tdata[11:8]));
        check_field("offset_value", due_head.offset_value, out_tdata[43:12]);
        check_field("size_value", due_head.size_value, out_tdata[75:44]);
        check_field("offset_valid", 32'(due_head.offset_valid), 32'(out_tdata[76]));
        check_field("size_valid", 32'(due_head.size_valid), 32'(out_tdata[77]));
      end
    end
  end

  always @(negedge clk) out_tready <= steady || ($urandom_range(0, 99) >= PCT_IDLE);

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL text_command_line_parser_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_char(input logic [7:0] c);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < PCT_IDLE) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    do @(posedge clk); while (!in_tready);
    parse_char(c);
    chars_sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic drain_results();
    release_input();
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_line(input string s);
    send_text(s);
    send_char(CH_END);
  endtask

  task automatic send_word(input string w);
    logic [7:0] c;
    for (int i = 0; i < w.len(); i++) begin
      c = w[i];
      if (c >= 8'h41 && c <= 8'h5A && $urandom_range(0, 1)) c = c + 8'h20;
      send_char(c);
    end
  endtask

  task automatic send_gap();
    repeat ($urandom_range(1, 3)) send_char(blanks[$urandom_range(0, 3)]);
  endtask

  task automatic send_number(input int unsigned n);
    repeat (n) send_char(8'(8'h30 + $urandom_range(0, 9)));
  endtask

  task automatic send_bad_arg();
    send_number($urandom_range(0, 3));
    if ($urandom_range(0, 1)) send_char(8'(8'h41 + $urandom_range(0, 25)));
    else send_char(8'(8'h80 + $urandom_range(0, 127)));
    send_number($urandom_range(0, 3));
  endtask

  task automatic send_payload(input int unsigned n);
    repeat (n) send_char(8'($urandom_range(8'h21, 8'hFF)));
  endtask

  task automatic send_junk(input int unsigned n);
    repeat (n) send_char(8'($urandom_range(1, 255)));
  endtask

  task automatic send_random_line();
    int unsigned pick;
    int unsigned k;
    int unsigned n_args;
    cmd_type_t   cmd;
    pick = $urandom_range(0, 99);
    k = $urandom_range(0, 15);
    cmd = kw_cmd[k];
    if ($urandom_range(0, 3) == 0) send_gap();
    if (pick < 72) begin
      send_word(kw_word[k]);
      case (cmd)
        CMD_READ: n_args = 2;
        CMD_ERASE, CMD_CRC, CMD_WRITE: n_args = 1;
        default: n_args = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
      endcase
      if (n_args != 0 && $urandom_range(0, 9) == 0) n_args--;
      repeat (n_args) begin
        send_gap();
        if ($urandom_range(0, 7) == 0) send_bad_arg();
        else send_number($urandom_range(1, 11));
      end
      if (cmd == CMD_WRITE && $urandom_range(0, 9) != 0) begin
        send_gap();
        send_payload(($urandom_range(0, 19) == 0) ? $urandom_range(60, 72)
                                                   : $urandom_range(1, 16));
        if ($urandom_range(0, 5) == 0) begin
          send_gap();
          send_payload($urandom_range(1, 4));
        end
      end
    end else if (pick < 85) begin
      send_junk($urandom_range(1, 30));
    end else if (pick < 92) begin
      if ($urandom_range(0, 1)) begin
        send_word(kw_word[k]);
        send_char(8'(8'h41 + $urandom_range(0, 25)));
      end else begin
        send_word(kw_word[k].substr(0, kw_word[k].len() - 2));
      end
      if ($urandom_range(0, 1)) begin
        send_gap();
        send_number($urandom_range(1, 5));
      end
    end else if (pick < 97) begin
      if ($urandom_range(0, 1)) send_gap();
    end else begin
      repeat ($urandom_range(28, 40)) send_char(8'(8'h41 + $urandom_range(0, 25)));
      send_gap();
      send_number($urandom_range(28, 40));
      send_gap();
      send_number(3);
    end
    if ($urandom_range(0, 3) == 0) send_gap();
    send_char(CH_END);
  endtask

  task automatic test_keywords();
    send_line("ping");
    send_line("HeLp");
    send_line("?");
    send_line("info");
    send_line("Status");
    send_line("diag");
    send_line("flash");
    send_line("map");
    send_line("read 16 32");
    send_line("dump\t4294967295 1");
    send_line("erase 4096");
    send_line("write 8 Hi!z");
    send_line("crc 99");
    send_line("boot");
    send_line("start");
    send_line("reset");
    send_line("bogus");
  endtask

  task automatic test_blank_lines();
    send_char(CH_END);
    send_line(" \t\r\n");
    send_line("\r\n  PING \n");
  endtask

  task automatic test_high_bytes();
    send_char("P");
    send_char(8'hC9);
    send_text("NG");
    send_char(CH_END);
    send_text("write 3 ");
    send_char(8'hFF);
    send_char(8'h80);
    send_char(8'h7F);
    send_char(8'h01);
    send_text("az");
    send_char(CH_END);
    send_text("erase 1");
    send_char(8'hB5);
    send_char(CH_END);
  endtask

  task automatic test_failed_args();
    send_line("read 12");
    send_line("dump 12 x");
    send_line("read a 1");
    send_line("write 5");
    send_line("write x yy");
    send_line("erase");
    send_line("crc 1a");
    send_line("ping extra args here");
    send_line("write 5 ab cd");
  endtask

  task automatic test_wrapping();
    send_line("erase 4294967296");
    send_line("crc 99999999999");
    send_line("read 0 0");
  endtask

  task automatic test_token_cuts();
    string s;
    s = "";
    repeat (KEYWORD_CHARS) s = {s, "A"};
    send_line({s, "PING 7"});
    s = "read ";
    repeat (ARG_CHARS + 4) s = {s, "9"};
    send_line({s, " 5"});
    s = "write 1 ";
    for (int i = 0; i < TEXT_CHARS + 3; i++) s = {s, $sformatf("%c", 8'h61 + (i % 26))};
    send_line(s);
  endtask

  task automatic test_sender_pause();
    send_text("write 2 abc");
    drain_results();
    send_line("def");
  endtask

  task automatic test_random_lines();
    int unsigned start;
    start = chars_sent;
    steady = 1'b1;
    while (chars_sent < start + STEADY_CHARS) send_random_line();
    steady = 1'b0;
    while (chars_sent < start + RANDOM_CHARS) send_random_line();
  endtask

  initial begin
    clear_line();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_keywords();
    test_blank_lines();
    test_high_bytes();
    test_failed_args();
    test_wrapping();
    test_token_cuts();
    test_sender_pause();
    test_random_lines();
    drain_results();
    repeat (10) @(posedge clk);
    if (fails == 0) $display("PASS text_command_line_parser_core");
    else $display("FAIL text_command_line_parser_core");
    $finish;
  end

endmodule

`default_nettype wire
